[rtl/core/mandelbrot_escape_shader_top_defines.svh]
// Assertion macros for the escape-time shader checker.
// Needs nothing else; taken in by the checker file only.
`ifndef MANDELBROT_ESCAPE_SHADER_TOP_DEFINES_SVH
`define MANDELBROT_ESCAPE_SHADER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MES_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/mes_pkg.sv]
// Shared types, constants and helper functions of the escape-time shader.
// No dependencies; the RTL files refer to it by scoped names, the verification files import it.
package mes_pkg;

	localparam int Q_FRAC      = 28;
	localparam int COORD_W     = 32;
	localparam int HSPAN_W     = 31;
	localparam int PIX_W       = 9;
	localparam int GRAY_W      = 8;
	localparam int COUNT_W     = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int SAT_IN_W    = 40;

	localparam int SCREEN_WIDTH_DEF   = 512;
	localparam int SCREEN_HEIGHT_DEF  = 512;
	localparam int MAX_ITERATIONS_DEF = 128;

	localparam int GRAY_MAX     = 255;
	localparam int ESCAPE_RADSQ = 4;

	localparam logic [HSPAN_W-1:0] HSPAN_RESET = 31'h2000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_REAL = 2'd0,
		REG_CENTER_IMAG = 2'd1,
		REG_HALF_SPAN   = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CMD_NONE     = 3'd0,
		CMD_MAP_MUL  = 3'd1,
		CMD_MAP_ADD  = 3'd2,
		CMD_ITER_MUL = 3'd3,
		CMD_ITER_ADD = 3'd4
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
	} cplx_ctrl_t;

	typedef struct packed {
		logic escaped;
	} cplx_stat_t;

	typedef struct packed {
		logic                       done;
		logic signed [COORD_W-1:0]  frac;
	} map_stat_t;

	// clamp to the signed 32-bit range
	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
		logic signed [SAT_IN_W-1:0] hi;
		logic signed [SAT_IN_W-1:0] lo;
		hi = SAT_IN_W'(64'sh0000_0000_7FFF_FFFF);
		lo = SAT_IN_W'(-64'sh0000_0000_8000_0000);
		if (v > hi)
			return COORD_W'(hi);
		else if (v < lo)
			return COORD_W'(lo);
		else
			return COORD_W'(v);
	endfunction

	// integer square root, used only to build the shading table
	function automatic logic [15:0] isqrt32(input logic [31:0] v);
		logic [31:0] rem;
		logic [31:0] r;
		logic [31:0] b;
		rem = v;
		r   = 32'd0;
		b   = 32'h4000_0000;
		for (int k = 0; k < 16; k++) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r   = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[15:0];
	endfunction

endpackage

[rtl/core/mes_if.sv]
// Valid/ready channel interfaces of the escape-time shader: pixel in, shade out.
// Depends on mes_pkg for field widths.
interface mes_pix_if;
	logic                           valid;
	logic                           ready;
	logic [mes_pkg::PIX_W-1:0]      pixel_x;
	logic [mes_pkg::PIX_W-1:0]      pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mes_shade_if;
	logic                           valid;
	logic                           ready;
	logic [mes_pkg::GRAY_W-1:0]     gray_level;
	logic [mes_pkg::COUNT_W-1:0]    escape_count;

	modport source (output valid, output gray_level, output escape_count, input ready);
	modport sink   (input valid, input gray_level, input escape_count, output ready);
endinterface

[rtl/core/mes_axis_map.sv]
// Screen fraction of one axis: floor((2p - SIZE) * 2^28 / SIZE), saturated to Q4.28.
// Constant split plus reciprocal multiplication by 1/SIZE, in a divide state and a finish state. Uses mes_pkg.
module mes_axis_map #(
	parameter int SIZE = mes_pkg::SCREEN_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mes_pkg::PIX_W-1:0]   pixel,
	output mes_pkg::map_stat_t          stat
);

	localparam int PMAX    = (1 << mes_pkg::PIX_W) * 2 - 2;
	localparam int MAG_MAX = (SIZE > PMAX) ? SIZE : PMAX;
	localparam int MAG_W   = $clog2(MAG_MAX + 1);
	localparam int SIZE_W  = $clog2(SIZE + 1);
	localparam int DW      = MAG_W + SIZE_W;
	localparam int NW      = MAG_W + 1;
	localparam int MQW     = MAG_W + mes_pkg::Q_FRAC;
	localparam int MGW     = MQW + 1;
	localparam int RS      = DW + SIZE_W;
	localparam int RW      = DW + 2;
	localparam int PRW     = DW + RW;
	localparam int Q_INT   = (1 << mes_pkg::Q_FRAC) / SIZE;
	localparam int RM_INT  = (1 << mes_pkg::Q_FRAC) % SIZE;
	localparam longint RECIP_INT = ((64'sd1 <<< RS) + longint'(SIZE) - 64'sd1) / longint'(SIZE);

	localparam logic [mes_pkg::Q_FRAC-1:0] Q_C     = mes_pkg::Q_FRAC'(Q_INT);
	localparam logic [SIZE_W-1:0]          RM_C    = SIZE_W'(RM_INT);
	localparam logic [RW-1:0]              RECIP_C = RW'(RECIP_INT);
	localparam logic [DW-1:0]              SIZE_C  = DW'(SIZE);
	localparam logic [MGW-1:0]             POS_LIM = MGW'(64'h7FFF_FFFF);
	localparam logic [MGW-1:0]             NEG_LIM = MGW'(64'h8000_0000);

	typedef enum logic [2:0] {
		M_IDLE = 3'b001,
		M_DIV  = 3'b010,
		M_FIN  = 3'b100
	} map_state_t;

	map_state_t                  state_q;
	logic                        done_q;
	logic                        neg_q;
	logic [MQW-1:0]              mq_q;
	logic [DW-1:0]               rx_q;
	logic [MAG_W-1:0]            quo_q;
	logic signed [mes_pkg::COORD_W-1:0] frac_q;

	logic signed [NW-1:0]        n;
	logic [MAG_W-1:0]            m;
	logic [MQW-1:0]              mq_next;
	logic [DW-1:0]               rx_next;
	logic [PRW-1:0]              rprod;
	logic                        inexact;
	logic [MGW-1:0]              mag;
	logic signed [mes_pkg::COORD_W-1:0] frac_next;

	assign n       = $signed(NW'({pixel, 1'b0}) - NW'(SIZE));
	assign m       = n[NW-1] ? MAG_W'(-n) : MAG_W'(n);
	assign mq_next = m * Q_C;
	assign rx_next = m * RM_C;
	// exact floor division of the remainder part by SIZE
	assign rprod   = rx_q * RECIP_C;
	assign inexact = (rx_q != DW'(quo_q) * SIZE_C);

	// ceiling of the remainder part for negative offsets
	assign mag = MGW'(mq_q) + MGW'(quo_q) + MGW'(neg_q && inexact);

	always_comb begin
		if (neg_q)
			frac_next = (mag > NEG_LIM) ? $signed(32'h8000_0000) : $signed(32'(~mag + 1'b1));
		else
			frac_next = (mag > POS_LIM) ? $signed(32'h7FFF_FFFF) : $signed(32'(mag));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_DIV;
						done_q  <= 1'b0;
					end
				end
				M_DIV: state_q <= M_FIN;
				M_FIN: begin
					state_q <= M_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && start) begin
			neg_q <= n[NW-1];
			mq_q  <= mq_next;
			rx_q  <= rx_next;
		end
		if (state_q == M_DIV)
			quo_q <= rprod[RS +: MAG_W];
		if (state_q == M_FIN)
			frac_q <= frac_next;
	end

	assign stat.done = done_q;
	assign stat.frac = frac_q;

endmodule

[rtl/core/mes_cplx_unit.sv]
// Shared complex multiply/add unit: scales the screen fractions, then iterates z = z^2 + c.
// Three registered 32x32 products, then saturation and update. Uses mes_pkg.
module mes_cplx_unit (
	input  logic                                clk,
	input  mes_pkg::cplx_ctrl_t                 ctrl,
	input  logic signed [mes_pkg::COORD_W-1:0]  t_x,
	input  logic signed [mes_pkg::COORD_W-1:0]  t_y,
	input  logic [mes_pkg::HSPAN_W-1:0]         half_span,
	input  logic signed [mes_pkg::COORD_W-1:0]  center_re,
	input  logic signed [mes_pkg::COORD_W-1:0]  center_im,
	output mes_pkg::cplx_stat_t                 stat
);

	localparam int CW  = mes_pkg::COORD_W;
	localparam int PW  = 2 * CW;
	localparam int QF  = mes_pkg::Q_FRAC;
	localparam int HW  = PW - QF;
	localparam int XW  = PW - QF + 1;
	localparam int SW  = mes_pkg::SAT_IN_W;
	localparam logic signed [HW:0] ESC_LIM = (HW + 1)'(mes_pkg::ESCAPE_RADSQ) << QF;

	logic signed [CW-1:0] a_q, b_q, cre_q, cim_q;
	logic signed [PW-1:0] p0_q, p1_q, p2_q;

	logic signed [CW-1:0] op0a, op0b, op1a, op1b;
	logic signed [PW-1:0] prod0, prod1, prod2;
	logic signed [HW-1:0] aa, bb;
	logic signed [XW-1:0] ab;
	logic signed [HW:0]   mag2;
	logic signed [CW-1:0] aa_s, bb_s, ab_s;
	logic signed [CW-1:0] a_new, b_new, cre_new, cim_new;
	logic signed [CW-1:0] hs_s;

	assign hs_s = $signed({1'b0, half_span});

	always_comb begin
		if (ctrl.cmd == mes_pkg::CMD_MAP_MUL) begin
			op0a = t_x;
			op0b = hs_s;
			op1a = t_y;
			op1b = hs_s;
		end else begin
			op0a = a_q;
			op0b = a_q;
			op1a = b_q;
			op1b = b_q;
		end
	end

	assign prod0 = op0a * op0b;
	assign prod1 = op1a * op1b;
	assign prod2 = a_q * b_q;

	// floor shifts are plain arithmetic part-selects
	assign aa   = p0_q[PW-1:QF];
	assign bb   = p1_q[PW-1:QF];
	assign ab   = p2_q[PW-1:QF-1];
	assign mag2 = (HW + 1)'(aa) + (HW + 1)'(bb);

	assign aa_s = mes_pkg::sat32(SW'(aa));
	assign bb_s = mes_pkg::sat32(SW'(bb));
	assign ab_s = mes_pkg::sat32(SW'(ab));

	assign a_new   = mes_pkg::sat32(SW'(aa_s) - SW'(bb_s) + SW'(cre_q));
	assign b_new   = mes_pkg::sat32(SW'(ab_s) + SW'(cim_q));
	assign cre_new = mes_pkg::sat32(SW'(aa) + SW'(center_re));
	assign cim_new = mes_pkg::sat32(SW'(bb) + SW'(center_im));

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			mes_pkg::CMD_MAP_MUL, mes_pkg::CMD_ITER_MUL: begin
				p0_q <= prod0;
				p1_q <= prod1;
				p2_q <= prod2;
			end
			mes_pkg::CMD_MAP_ADD: begin
				cre_q <= cre_new;
				cim_q <= cim_new;
				a_q   <= cre_new;
				b_q   <= cim_new;
			end
			mes_pkg::CMD_ITER_ADD: begin
				a_q <= a_new;
				b_q <= b_new;
			end
			default: ;
		endcase
	end

	assign stat.escaped = (mag2 >= ESC_LIM);

endmodule

[rtl/core/mandelbrot_escape_shader_top.sv]
// Mandelbrot escape-time shader, top level: registers, sequencer, shading table, output stage.
// Depends on mes_pkg, mes_if, mes_axis_map and mes_cplx_unit.
//
// Usage:
//   pix   : valid/ready sink, one transaction per pixel (pixel_x, pixel_y).
//   shade : valid/ready source, one transaction per pixel (gray_level, escape_count).
//   cfg_* : write-only register port; index 0 centre real, 1 centre imaginary,
//           2 half span. Write only while no pixel is in flight.
// One pixel is processed at a time; pix.ready is high only when the sequencer is idle.
// With n escape-loop passes (escape_count, or MAX_ITERATIONS - 1 inside the set),
// shade.valid rises after mapping, scaling, n passes on the shared complex unit
// (registered products, then saturate and update), one table read and one output
// load. The next pixel can be taken in the cycle in which shade.valid rises.
// The result sits in an output register, so the next pixel is taken while it waits;
// a stalled receiver holds the result stable and only blocks the pixel after that.
// Reset: asynchronous, active low; clears the sequencer and output valid and loads
// the register defaults (centre 0, half span 2.0).
module mandelbrot_escape_shader_top #(
	parameter int SCREEN_WIDTH   = mes_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT  = mes_pkg::SCREEN_HEIGHT_DEF,
	parameter int MAX_ITERATIONS = mes_pkg::MAX_ITERATIONS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mes_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mes_pkg::CFG_DATA_W-1:0]      cfg_data,
	mes_pix_if.sink                             pix,
	mes_shade_if.source                         shade
);

	localparam int CW    = $clog2(MAX_ITERATIONS + 1);
	localparam int ROM_D = 1 << CW;
	localparam int GW    = mes_pkg::GRAY_W;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_MAP      = 7'b0000010,
		S_MAP_ADD  = 7'b0000100,
		S_ITER_MUL = 7'b0001000,
		S_ITER_ADD = 7'b0010000,
		S_SHADE    = 7'b0100000,
		S_DONE     = 7'b1000000
	} state_t;

	state_t                                state_q, state_d;
	logic [CW-1:0]                         count_q;
	logic                                  out_valid_q;
	logic [GW-1:0]                         gray_rd_q;
	logic [GW-1:0]                         out_gray_q;
	logic [mes_pkg::COUNT_W-1:0]           out_count_q;
	logic signed [mes_pkg::COORD_W-1:0]    center_re_q;
	logic signed [mes_pkg::COORD_W-1:0]    center_im_q;
	logic [mes_pkg::HSPAN_W-1:0]           half_span_q;

	logic                                  start;
	logic                                  out_free;
	logic [CW-1:0]                         count_inc;
	mes_pkg::map_stat_t                    map_x, map_y;
	mes_pkg::cplx_ctrl_t                   cplx_ctrl;
	mes_pkg::cplx_stat_t                   cplx_stat;
	logic [GW-1:0]                         gray_rom [ROM_D];

	// shading table: floor(255 * sqrt(n / max)), zero for n at or past the maximum
	for (genvar gi = 0; gi < ROM_D; gi++) begin : g_rom
		localparam int unsigned ARG =
			(mes_pkg::GRAY_MAX * mes_pkg::GRAY_MAX * gi) / MAX_ITERATIONS;
		assign gray_rom[gi] = (gi >= MAX_ITERATIONS) ? '0 : GW'(mes_pkg::isqrt32(32'(ARG)));
	end

	assign start     = pix.valid && pix.ready;
	assign out_free  = !out_valid_q || shade.ready;
	assign count_inc = count_q + 1'b1;
	assign pix.ready = (state_q == S_IDLE);

	mes_axis_map #(.SIZE(SCREEN_WIDTH)) u_map_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.pixel  (pix.pixel_x),
		.stat   (map_x)
	);

	mes_axis_map #(.SIZE(SCREEN_HEIGHT)) u_map_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.pixel  (pix.pixel_y),
		.stat   (map_y)
	);

	mes_cplx_unit u_cplx (
		.clk       (clk),
		.ctrl      (cplx_ctrl),
		.t_x       (map_x.frac),
		.t_y       (map_y.frac),
		.half_span (half_span_q),
		.center_re (center_re_q),
		.center_im (center_im_q),
		.stat      (cplx_stat)
	);

	always_comb begin
		state_d       = state_q;
		cplx_ctrl.cmd = mes_pkg::CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (start)
					state_d = S_MAP;
			end
			S_MAP: begin
				if (map_x.done && map_y.done) begin
					cplx_ctrl.cmd = mes_pkg::CMD_MAP_MUL;
					state_d       = S_MAP_ADD;
				end
			end
			S_MAP_ADD: begin
				cplx_ctrl.cmd = mes_pkg::CMD_MAP_ADD;
				state_d       = S_ITER_MUL;
			end
			S_ITER_MUL: begin
				cplx_ctrl.cmd = mes_pkg::CMD_ITER_MUL;
				state_d       = S_ITER_ADD;
			end
			S_ITER_ADD: begin
				cplx_ctrl.cmd = mes_pkg::CMD_ITER_ADD;
				if (cplx_stat.escaped || count_inc >= CW'(MAX_ITERATIONS))
					state_d = S_SHADE;
				else
					state_d = S_ITER_MUL;
			end
			S_SHADE: state_d = S_DONE;
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			center_re_q <= '0;
			center_im_q <= '0;
			half_span_q <= mes_pkg::HSPAN_RESET;
		end else begin
			state_q <= state_d;
			if (state_q == S_MAP_ADD)
				count_q <= CW'(1);
			else if (state_q == S_ITER_ADD && !cplx_stat.escaped)
				count_q <= count_inc;
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (shade.ready)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (mes_pkg::cfg_reg_t'(cfg_index))
					mes_pkg::REG_CENTER_REAL: center_re_q <= $signed(cfg_data);
					mes_pkg::REG_CENTER_IMAG: center_im_q <= $signed(cfg_data);
					mes_pkg::REG_HALF_SPAN:   half_span_q <= cfg_data[mes_pkg::HSPAN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SHADE)
			gray_rd_q <= gray_rom[count_q];
		if (state_q == S_DONE && out_free) begin
			out_gray_q  <= gray_rd_q;
			out_count_q <= mes_pkg::COUNT_W'(count_q);
		end
	end

	assign shade.valid        = out_valid_q;
	assign shade.gray_level   = out_gray_q;
	assign shade.escape_count = out_count_q;

endmodule

[rtl/core/mes_checker.sv]
// Port-level checker of the escape-time shader, bound to the top level.
// Depends on the assertion macro header and on mandelbrot_escape_shader_top.
`include "mandelbrot_escape_shader_top_defines.svh"

module mes_checker #(
	parameter int MAX_ITERATIONS = mes_pkg::MAX_ITERATIONS_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [mes_pkg::GRAY_W-1:0]          gray_level,
	input logic [mes_pkg::COUNT_W-1:0]         escape_count
);

	localparam logic [mes_pkg::COUNT_W-1:0] COUNT_AT_MAX = mes_pkg::COUNT_W'(MAX_ITERATIONS);
	localparam logic                        TABLE_EXACT  = (MAX_ITERATIONS <= 256);

	`MES_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`MES_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(gray_level) && $stable(escape_count), "result changed while stalled")
	`MES_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready, "second pixel taken while busy")
	`MES_ASSERT_SAME(a_gray_inside, clk, arst_n, out_valid && TABLE_EXACT, (gray_level == '0) == (escape_count == COUNT_AT_MAX), "gray level disagrees with escape count")

endmodule

bind mandelbrot_escape_shader_top mes_checker #(
	.MAX_ITERATIONS (MAX_ITERATIONS)
) u_mes_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pix.valid),
	.in_ready     (pix.ready),
	.out_valid    (shade.valid),
	.out_ready    (shade.ready),
	.gray_level   (shade.gray_level),
	.escape_count (shade.escape_count)
);

[verif/mes_shade_checker.sv]
`timescale 1ns / 100ps
// Checker for the escape-time shader: watches the register port and both channels,
// predicts gray level and escape count per pixel transaction and compares each shade.
// Depends on mes_pkg and the channel interfaces of mes_if.
module mes_shade_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mes_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mes_pkg::CFG_DATA_W-1:0]  cfg_data,
	mes_pix_if                              pix,
	mes_shade_if                            shade,
	output int                              fail_count,
	output int                              pending
);
	import mes_pkg::*;

	localparam longint Q_ONE     = 64'sd1 <<< Q_FRAC;
	localparam longint ESC_LIMIT = ESCAPE_RADSQ * Q_ONE;
	localparam longint POS_MAX   = 64'sd2147483647;
	localparam longint NEG_MIN   = -64'sd2147483648;
	localparam int     PRINT_CAP = 200;

	typedef struct packed {
		logic [GRAY_W-1:0]  gray_level;
		logic [COUNT_W-1:0] escape_count;
	} shade_t;

	logic signed [COORD_W-1:0] view_re;
	logic signed [COORD_W-1:0] view_im;
	logic [HSPAN_W-1:0]        view_span;
	shade_t                    shade_expect[$];
	int                        shade_seen;

	initial begin
		fail_count = 0;
		pending    = 0;
		shade_seen = 0;
	end

	function automatic longint clamp32(input longint v);
		if (v > POS_MAX)
			return POS_MAX;
		if (v < NEG_MIN)
			return NEG_MIN;
		return v;
	endfunction

	// screen index to plane coordinate, both divisions rounding towards minus infinity
	function automatic longint plane_coord(input longint p, input longint size,
			input longint centre, input longint span);
		longint num;
		longint frac;
		num = (2 * p - size) * Q_ONE;
		if (num >= 0)
			frac = num / size;
		else
			frac = -((-num + size - 1) / size);
		frac = clamp32(frac);
		return clamp32(((frac * span) >>> Q_FRAC) + centre);
	endfunction

	function automatic int unsigned root_floor(input int unsigned v);
		int unsigned r;
		r = 0;
		while ((r + 1) * (r + 1) <= v)
			r++;
		return r;
	endfunction

	function automatic shade_t escape_shade(input logic [PIX_W-1:0] px,
			input logic [PIX_W-1:0] py);
		longint      c_re;
		longint      c_im;
		longint      a;
		longint      b;
		longint      aa;
		longint      bb;
		longint      ab;
		int unsigned n;
		shade_t      res;
		c_re = plane_coord(longint'(px), SCREEN_WIDTH_DEF, longint'(view_re),
			longint'(view_span));
		c_im = plane_coord(longint'(py), SCREEN_HEIGHT_DEF, longint'(view_im),
			longint'(view_span));
		a = c_re;
		b = c_im;
		n = 0;
		while (1) begin
			n++;
			if (n >= MAX_ITERATIONS_DEF)
				break;
			aa = (a * a) >>> Q_FRAC;
			bb = (b * b) >>> Q_FRAC;
			// escape test on the unclamped squares
			if (aa + bb >= ESC_LIMIT)
				break;
			ab = clamp32((a * b) >>> (Q_FRAC - 1));
			a  = clamp32(clamp32(aa) - clamp32(bb) + c_re);
			b  = clamp32(ab + c_im);
		end
		res.escape_count = COUNT_W'(n);
		if (n == MAX_ITERATIONS_DEF)
			res.gray_level = '0;
		else
			res.gray_level = GRAY_W'(root_floor(GRAY_MAX * GRAY_MAX * n / MAX_ITERATIONS_DEF));
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < PRINT_CAP)
			$display("%0t shade check: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		shade_t want;
		if (!arst_n) begin
			view_re   = '0;
			view_im   = '0;
			view_span = HSPAN_RESET;
			shade_expect.delete();
		end else begin
			if (pix.valid && pix.ready)
				shade_expect.push_back(escape_shade(pix.pixel_x, pix.pixel_y));
			if (shade.valid && shade.ready) begin
				shade_seen++;
				if (shade_expect.size() == 0) begin
					report_mismatch($sformatf("transaction %0d unexpected (gray %0d, count %0d)",
						shade_seen, shade.gray_level, shade.escape_count));
				end else begin
					want = shade_expect.pop_front();
					if (shade.gray_level !== want.gray_level)
						report_mismatch($sformatf("transaction %0d gray_level %0d, expected %0d",
							shade_seen, shade.gray_level, want.gray_level));
					if (shade.escape_count !== want.escape_count)
						report_mismatch($sformatf("transaction %0d escape_count %0d, expected %0d",
							shade_seen, shade.escape_count, want.escape_count));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				REG_CENTER_REAL: view_re = cfg_data;
				REG_CENTER_IMAG: view_im = cfg_data;
				REG_HALF_SPAN:   view_span = cfg_data[HSPAN_W-1:0];
				default: ; // no register behind this index
				endcase
			end
		end
		pending = shade_expect.size();
	end

endmodule

[verif/mandelbrot_escape_shader_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the escape-time shader: clock, reset, register writes, pixel and
// shade traffic with idling and a long hold-off, watchdog and verdict.
// Depends on mes_pkg, mes_if, the shader RTL and mes_shade_checker.
module mandelbrot_escape_shader_top_tb;
	import mes_pkg::*;

	// longest quiet stretch of a correct run is the hold-off plus two slow pixels
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 2000;
	localparam int HOLD_AT        = 150;
	localparam int VIEW_COUNT     = 8;
	localparam int PIX_PER_VIEW   = 240;
	localparam int IDLE_SWAP      = 640;
	localparam int IDLE_OFF       = 1280;
	localparam int TAIL_CYCLES    = 300;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [PIX_W-1:0]     PIX_LAST   = PIX_W'(SCREEN_WIDTH_DEF - 1);
	localparam logic [PIX_W-1:0]     PIX_MID    = PIX_W'(SCREEN_WIDTH_DEF / 2);

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int quiet_cycles;
	int pix_sent;
	int src_idle_pct;
	int sink_idle_pct;
	bit hold_req;

	mes_pix_if   pix_ch ();
	mes_shade_if shade_ch ();

	mandelbrot_escape_shader_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix_ch),
		.shade     (shade_ch)
	);

	mes_shade_checker shade_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix        (pix_ch),
		.shade      (shade_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (pix_ch.valid && pix_ch.ready) || (shade_ch.valid && shade_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("mandelbrot_escape_shader_top_tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [PIX_W-1:0] pick_coord();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return PIX_LAST;
		default: return PIX_W'($urandom_range(0, SCREEN_WIDTH_DEF - 1));
		endcase
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
		if (pix_sent < IDLE_SWAP) begin
			src_idle_pct  = 33;
			sink_idle_pct = 49;
		end else if (pix_sent < IDLE_OFF) begin
			src_idle_pct  = 49;
			sink_idle_pct = 33;
		end else begin
			src_idle_pct  = 0;
			sink_idle_pct = 0;
		end
		if (pix_sent == HOLD_AT)
			hold_req <= 1'b1;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid   <= 1'b1;
		pix_ch.pixel_x <= x;
		pix_ch.pixel_y <= y;
		do @(posedge clk); while (!pix_ch.ready);
		pix_sent++;
	endtask

	task automatic drain_shades();
		pix_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_view(input logic [CFG_DATA_W-1:0] re, input logic [CFG_DATA_W-1:0] im,
			input logic [CFG_DATA_W-1:0] span);
		cfg_we    <= 1'b1;
		cfg_index <= REG_UNUSED;
		cfg_data  <= $urandom();
		@(posedge clk);
		cfg_index <= REG_CENTER_REAL;
		cfg_data  <= re;
		@(posedge clk);
		cfg_index <= REG_CENTER_IMAG;
		cfg_data  <= im;
		@(posedge clk);
		cfg_index <= REG_HALF_SPAN;
		cfg_data  <= span;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : shade_drain
		int k;
		bit hold_done;
		shade_ch.ready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				// result register fills, then pix.ready drops while pixels are offered
				for (k = 0; k < HOLD_CYCLES; k++) begin
					shade_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
			shade_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] re;
		logic [CFG_DATA_W-1:0] im;
		logic [CFG_DATA_W-1:0] span;
		int view;
		int k;
		cfg_we         = 1'b0;
		cfg_index      = REG_CENTER_REAL;
		cfg_data       = '0;
		pix_ch.valid   = 1'b0;
		pix_ch.pixel_x = '0;
		pix_ch.pixel_y = '0;
		hold_req       = 1'b0;
		quiet_cycles   = 0;
		pix_sent       = 0;
		src_idle_pct   = 0;
		sink_idle_pct  = 0;
		arst_n         = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset view: corners, centre, axes, alternating bits
		send_pixel('0, '0);
		send_pixel(PIX_LAST, PIX_LAST);
		send_pixel('0, PIX_LAST);
		send_pixel(PIX_LAST, '0);
		send_pixel(PIX_MID, PIX_MID);
		send_pixel(PIX_MID, '0);
		send_pixel('0, PIX_MID);
		send_pixel(PIX_MID - 1'b1, PIX_MID - 1'b1);
		send_pixel(9'h155, 9'h0AA);
		send_pixel(9'h0AA, 9'h155);
		send_pixel(9'd384, PIX_MID);
		send_pixel(9'd128, 9'd300);
		send_pixel(9'd300, 9'd128);

		for (view = 0; view < VIEW_COUNT; view++) begin
			drain_shades();
			case (view)
			0: begin
				re   = 32'hF800_0000;
				im   = 32'h0000_0000;
				span = 32'h2000_0000;
			end
			1: begin
				re   = 32'h7FFF_FFFF;
				im   = 32'h8000_0000;
				span = 32'h7FFF_FFFF;
			end
			2: begin
				// span bits all clear: every pixel lands on the centre
				re   = 32'hF400_0000;
				im   = 32'h0199_999A;
				span = 32'h8000_0000;
			end
			3: begin
				re   = 32'hF400_0000;
				im   = 32'h0199_999A;
				span = 32'h0080_0000;
			end
			4: begin
				re   = 32'h0000_0000;
				im   = 32'h0000_0000;
				span = 32'h1000_0000;
			end
			5: begin
				re   = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
				im   = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
				span = 32'h0000_0001;
			end
			6: begin
				re   = 32'h8000_0000;
				im   = 32'h7FFF_FFFF;
				span = 32'hFFFF_FFFF;
			end
			default: begin
				re   = $urandom();
				im   = $urandom();
				span = $urandom();
			end
			endcase
			write_view(re, im, span);
			for (k = 0; k < PIX_PER_VIEW; k++)
				send_pixel(pick_coord(), pick_coord());
		end

		drain_shades();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("mandelbrot_escape_shader_top_tb: PASS");
		else
			$display("mandelbrot_escape_shader_top_tb: FAIL");
		$finish;
	end

endmodule
